// File: hdl/gbn_pkg.sv
package gbn_pkg;

  // command codes on the input channel
  localparam logic [1:0] CmdSend    = 2'd0;
  localparam logic [1:0] CmdRecv    = 2'd1;
  localparam logic [1:0] CmdTimeout = 2'd2;

  // result kinds
  typedef enum logic [1:0] {
    KindTx      = 2'd0,
    KindDeliver = 2'd1,
    KindStop    = 2'd2,
    KindRefuse  = 2'd3
  } kind_e;

  // most result words one command may produce
  localparam int unsigned MaxResults = 8;
  localparam int unsigned NResBits   = $clog2(MaxResults) + 1;

endpackage

// File: hdl/gbn_if.sv
interface gbn_cmd_if #(
  parameter int unsigned SEQ_BITS     = 3,
  parameter int unsigned PAYLOAD_BITS = 32
);
  logic                    valid;
  logic                    ready;
  logic [1:0]              command;
  logic [SEQ_BITS-1:0]     frame_seq;
  logic [SEQ_BITS-1:0]     frame_ack;
  logic [PAYLOAD_BITS-1:0] payload;

  modport source (output valid, command, frame_seq, frame_ack, payload, input ready);
  modport sink   (input valid, command, frame_seq, frame_ack, payload, output ready);
endinterface

interface gbn_res_if #(
  parameter int unsigned SEQ_BITS     = 3,
  parameter int unsigned PAYLOAD_BITS = 32
);
  import gbn_pkg::*;
  logic                    valid;
  logic                    ready;
  kind_e                   kind;
  logic [SEQ_BITS-1:0]     seq_number;
  logic [SEQ_BITS-1:0]     ack_number;
  logic [PAYLOAD_BITS-1:0] data_out;
  logic [SEQ_BITS-1:0]     outstanding;
  logic                    last;

  modport source (output valid, kind, seq_number, ack_number, data_out, outstanding, last,
                  input ready);
  modport sink   (input valid, kind, seq_number, ack_number, data_out, outstanding, last,
                  output ready);
endinterface

interface gbn_cfg_if #(
  parameter int unsigned SEQ_BITS = 3
);
  logic                valid;
  logic                ready;
  logic [SEQ_BITS-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// File: hdl/go_back_n_window.sv
// Channel  | Dir | Payload                                             | Word
// cmd_i    | in  | command, frame_seq, frame_ack, payload              | one command
// res_o    | out | kind, seq_number, ack_number, data_out,             | one result
//          |     | outstanding, last                                   |
// cfg_i    | in  | data (max_sequence)                                 | register write
//
// One command at a time. Send: one result. Receive: a deliver for an in-order frame,
// then one per retired frame. Timeout: one per outstanding frame (at most 8 results).
// The single sequencer with its shared step/window unit and the one output register
// emit one result word per cycle while res_o takes them; the send store read port is
// prefetched one ahead. Reset (rst_ni low, async) empties the window, zeroes all
// sequence numbers and sets max_sequence to 7. A stall on res_o holds the sequencer in
// place; cmd_i is taken only while the sequencer idles.
module go_back_n_window #(
  parameter int unsigned SEQ_BITS     = 3,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  gbn_cmd_if.sink   cmd_i,
  gbn_res_if.source res_o,
  gbn_cfg_if.sink   cfg_i
);
  import gbn_pkg::*;

  localparam logic [SEQ_BITS-1:0] MaxSeqReset = SEQ_BITS'(7);
  localparam int unsigned CmpBits = ((SEQ_BITS > NResBits) ? SEQ_BITS : NResBits) + 1;
  localparam logic [NResBits-1:0] NResLimit = NResBits'(MaxResults);

  typedef enum logic [2:0] {
    StIdle,
    StSend,
    StRecv,
    StRetire,
    StTout
  } state_e;

  state_e state_q, state_d;

  // window state
  logic [SEQ_BITS-1:0] max_q, max_d;
  logic [SEQ_BITS-1:0] next_q, next_d;
  logic [SEQ_BITS-1:0] oldest_q, oldest_d;
  logic [SEQ_BITS-1:0] recv_q, recv_d;
  logic [SEQ_BITS-1:0] count_q, count_d;
  logic [NResBits-1:0] n_q, n_d;

  // latched command word
  logic [SEQ_BITS-1:0]     fseq_q, fseq_d;
  logic [SEQ_BITS-1:0]     fack_q, fack_d;
  logic [PAYLOAD_BITS-1:0] payload_q, payload_d;

  // output register
  logic                    res_valid_q, res_valid_d;
  kind_e                   res_kind_q, res_kind_d;
  logic [SEQ_BITS-1:0]     res_seq_q, res_seq_d;
  logic [SEQ_BITS-1:0]     res_ack_q, res_ack_d;
  logic [PAYLOAD_BITS-1:0] res_data_q, res_data_d;
  logic [SEQ_BITS-1:0]     res_out_q, res_out_d;
  logic                    res_last_q, res_last_d;

  // shared unit hookup
  logic [SEQ_BITS-1:0] up_x, up_val, down_val, win_a;
  logic                win;

  // store hookup
  logic                    st_we;
  logic [SEQ_BITS-1:0]     st_raddr;
  logic [PAYLOAD_BITS-1:0] st_rdata;

  logic                slot_free;
  logic                more;
  logic [NResBits-1:0] n_inc;
  logic [SEQ_BITS-1:0] count_dec;

  gbn_seq_unit #(.SEQ_BITS(SEQ_BITS)) u_seq (
    .max_i    (max_q),
    .up_x_i   (up_x),
    .down_x_i (recv_q),
    .win_a_i  (win_a),
    .win_b_i  (fack_q),
    .win_c_i  (next_q),
    .up_o     (up_val),
    .down_o   (down_val),
    .win_o    (win)
  );

  gbn_store #(.SEQ_BITS(SEQ_BITS), .PAYLOAD_BITS(PAYLOAD_BITS)) u_store (
    .clk_i   (clk_i),
    .we_i    (st_we),
    .waddr_i (next_q),
    .wdata_i (payload_q),
    .raddr_i (st_raddr),
    .rdata_o (st_rdata)
  );

  assign slot_free = !res_valid_q || res_o.ready;
  assign n_inc     = n_q + 1'b1;
  assign count_dec = count_q - 1'b1;

  // step operand and window base depend on the phase
  always_comb begin
    up_x  = next_q;
    win_a = oldest_q;
    unique case (state_q)
      StRecv: begin
        up_x = recv_q;
      end
      StRetire: begin
        up_x  = oldest_q;
        win_a = up_val;   // look one frame ahead to find the last retire
      end
      default: ;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    max_d       = max_q;
    next_d      = next_q;
    oldest_d    = oldest_q;
    recv_d      = recv_q;
    count_d     = count_q;
    n_d         = n_q;
    fseq_d      = fseq_q;
    fack_d      = fack_q;
    payload_d   = payload_q;
    res_valid_d = res_valid_q && !res_o.ready;
    res_kind_d  = res_kind_q;
    res_seq_d   = res_seq_q;
    res_ack_d   = res_ack_q;
    res_data_d  = res_data_q;
    res_out_d   = res_out_q;
    res_last_d  = res_last_q;
    st_we       = 1'b0;
    st_raddr    = next_q;
    more        = 1'b0;

    if (cfg_i.valid) begin
      max_d = cfg_i.data;
    end

    unique case (state_q)
      StIdle: begin
        if (cmd_i.valid) begin
          fseq_d    = cmd_i.frame_seq;
          fack_d    = cmd_i.frame_ack;
          payload_d = cmd_i.payload;
          n_d       = '0;
          case (cmd_i.command)
            CmdSend: state_d = StSend;
            CmdRecv: state_d = StRecv;
            CmdTimeout: begin
              // rewind and prefetch the oldest frame
              next_d   = oldest_q;
              st_raddr = oldest_q;
              if (count_q != '0) begin
                state_d = StTout;
              end
            end
            default: ;
          endcase
        end
      end

      StSend: begin
        if (slot_free) begin
          res_valid_d = 1'b1;
          res_last_d  = 1'b1;
          state_d     = StIdle;
          if (count_q >= max_q) begin
            res_kind_d = KindRefuse;
            res_seq_d  = '0;
            res_ack_d  = '0;
            res_data_d = '0;
            res_out_d  = count_q;
          end else begin
            st_we      = 1'b1;
            count_d    = count_q + 1'b1;
            res_kind_d = KindTx;
            res_seq_d  = next_q;
            res_ack_d  = down_val;
            res_data_d = payload_q;
            res_out_d  = count_q + 1'b1;
            next_d     = up_val;
          end
        end
      end

      StRecv: begin
        more = (count_q != '0) && win;
        if (fseq_q == recv_q) begin
          if (slot_free) begin
            res_valid_d = 1'b1;
            res_kind_d  = KindDeliver;
            res_seq_d   = '0;
            res_ack_d   = '0;
            res_data_d  = payload_q;
            res_out_d   = count_q;
            res_last_d  = !more;
            recv_d      = up_val;
            n_d         = n_inc;
            state_d     = more ? StRetire : StIdle;
          end
        end else begin
          state_d = more ? StRetire : StIdle;
        end
      end

      StRetire: begin
        more = (count_dec != '0) && win && (n_inc != NResLimit);
        if (slot_free) begin
          res_valid_d = 1'b1;
          res_kind_d  = KindStop;
          res_seq_d   = oldest_q;
          res_ack_d   = '0;
          res_data_d  = '0;
          res_out_d   = count_dec;
          res_last_d  = !more;
          count_d     = count_dec;
          oldest_d    = up_val;
          n_d         = n_inc;
          if (!more) begin
            state_d = StIdle;
          end
        end
      end

      StTout: begin
        more = (CmpBits'(n_inc) < CmpBits'(count_q)) && (n_inc != NResLimit);
        if (slot_free) begin
          res_valid_d = 1'b1;
          res_kind_d  = KindTx;
          res_seq_d   = next_q;
          res_ack_d   = down_val;
          res_data_d  = st_rdata;
          res_out_d   = count_q;
          res_last_d  = !more;
          next_d      = up_val;
          st_raddr    = up_val;   // prefetch the following frame
          n_d         = n_inc;
          if (!more) begin
            state_d = StIdle;
          end
        end
      end

      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      max_q       <= MaxSeqReset;
      next_q      <= '0;
      oldest_q    <= '0;
      recv_q      <= '0;
      count_q     <= '0;
      n_q         <= '0;
      fseq_q      <= '0;
      fack_q      <= '0;
      payload_q   <= '0;
      res_valid_q <= 1'b0;
      res_kind_q  <= KindTx;
      res_seq_q   <= '0;
      res_ack_q   <= '0;
      res_data_q  <= '0;
      res_out_q   <= '0;
      res_last_q  <= 1'b0;
    end else begin
      state_q     <= state_d;
      max_q       <= max_d;
      next_q      <= next_d;
      oldest_q    <= oldest_d;
      recv_q      <= recv_d;
      count_q     <= count_d;
      n_q         <= n_d;
      fseq_q      <= fseq_d;
      fack_q      <= fack_d;
      payload_q   <= payload_d;
      res_valid_q <= res_valid_d;
      res_kind_q  <= res_kind_d;
      res_seq_q   <= res_seq_d;
      res_ack_q   <= res_ack_d;
      res_data_q  <= res_data_d;
      res_out_q   <= res_out_d;
      res_last_q  <= res_last_d;
    end
  end

  assign cmd_i.ready       = (state_q == StIdle);
  assign cfg_i.ready       = 1'b1;
  assign res_o.valid       = res_valid_q;
  assign res_o.kind        = res_kind_q;
  assign res_o.seq_number  = res_seq_q;
  assign res_o.ack_number  = res_ack_q;
  assign res_o.data_out    = res_data_q;
  assign res_o.outstanding = res_out_q;
  assign res_o.last        = res_last_q;

  // each retire step takes exactly one frame off the window
  a_retire_dec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StRetire && slot_free) |=> (count_q == $past(count_dec)))
    else $error("retire did not decrement outstanding count");

  // retransmission only runs with frames outstanding
  a_tout_nonempty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StTout) |-> (count_q != '0))
    else $error("retransmission with empty window");

  // loading the final result word returns the sequencer to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle && slot_free && res_valid_d && res_last_d) |=> (state_q == StIdle))
    else $error("sequencer busy after final result");

  // result count per command stays within bound
  a_n_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != StIdle) |-> (n_q < NResLimit))
    else $error("too many results for one command");

endmodule

// File: hdl/gbn_seq_unit.sv
// Shared modular sequence unit: step up, step down, window test.
module gbn_seq_unit #(
  parameter int unsigned SEQ_BITS = 3
) (
  input  logic [SEQ_BITS-1:0] max_i,
  input  logic [SEQ_BITS-1:0] up_x_i,
  input  logic [SEQ_BITS-1:0] down_x_i,
  input  logic [SEQ_BITS-1:0] win_a_i,
  input  logic [SEQ_BITS-1:0] win_b_i,
  input  logic [SEQ_BITS-1:0] win_c_i,
  output logic [SEQ_BITS-1:0] up_o,
  output logic [SEQ_BITS-1:0] down_o,
  output logic                win_o
);

  assign up_o   = (up_x_i >= max_i) ? '0 : up_x_i + 1'b1;
  assign down_o = (down_x_i == '0 || down_x_i > max_i) ? max_i : down_x_i - 1'b1;

  // b lies in [a, c) on the modular ring
  assign win_o = ((win_a_i <= win_b_i) && (win_b_i < win_c_i)) ||
                 ((win_c_i < win_a_i) && (win_a_i <= win_b_i)) ||
                 ((win_b_i < win_c_i) && (win_c_i < win_a_i));

endmodule

// File: hdl/gbn_store.sv
// Send store: one write port, one registered read port.
module gbn_store #(
  parameter int unsigned SEQ_BITS     = 3,
  parameter int unsigned PAYLOAD_BITS = 32
) (
  input  logic                    clk_i,
  input  logic                    we_i,
  input  logic [SEQ_BITS-1:0]     waddr_i,
  input  logic [PAYLOAD_BITS-1:0] wdata_i,
  input  logic [SEQ_BITS-1:0]     raddr_i,
  output logic [PAYLOAD_BITS-1:0] rdata_o
);

  logic [PAYLOAD_BITS-1:0] mem_q [2**SEQ_BITS];
  logic [PAYLOAD_BITS-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
